[rtl/mpfp_pkg.sv]
// Shared types and constants for the position frame parser.
// Used by every module and by the bench; depends on nothing.
`default_nettype none
package mpfp_pkg;

    localparam logic [7:0]  STX_V1          = 8'hFE;
    localparam logic [7:0]  STX_V2          = 8'hFD;
    localparam logic [23:0] POS_MSG_ID      = 24'd33;
    localparam logic [7:0]  POS_MIN_LEN     = 8'd28;
    localparam logic [15:0] HDG_UNKNOWN     = 16'hFFFF;
    localparam int          INCOMPAT_SIGNED = 0;
    localparam logic [7:0]  TRAILER_PLAIN   = 8'd2;
    localparam logic [7:0]  TRAILER_SIGNED  = 8'd15;
    localparam logic [7:0]  HDR_LAST_V1     = 8'd5;
    localparam logic [7:0]  HDR_LAST_V2     = 8'd9;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        PH_HUNT    = 4'b0001,
        PH_HEADER  = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_TRAILER = 4'b1000
    } phase_t;

    // One finished position frame as the parser saw it.
    typedef struct packed {
        logic        short_payload;
        logic [31:0] lat;
        logic [31:0] lon;
        logic [31:0] alt;
        logic [31:0] vel;
        logic [15:0] hdg;
    } frame_t;

endpackage
`default_nettype wire

[rtl/mpfp_ifs.sv]
// Valid/ready channel interfaces for the byte stream and the position reports.
// Depends on nothing.
`default_nettype none
interface mpfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface mpfp_pos_if;
    logic               valid;
    logic               ready;
    logic               status;
    logic signed [31:0] lat_e7;
    logic signed [31:0] lon_e7;
    logic signed [31:0] alt_mm;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic        [15:0] heading_cdeg;
    logic               heading_valid;
    logic        [31:0] good_total;
    logic        [31:0] bad_total;

    modport source (output valid, output status, output lat_e7, output lon_e7,
                    output alt_mm, output vel_x, output vel_y, output heading_cdeg,
                    output heading_valid, output good_total, output bad_total,
                    input ready);
    modport sink   (input valid, input status, input lat_e7, input lon_e7,
                    input alt_mm, input vel_x, input vel_y, input heading_cdeg,
                    input heading_valid, input good_total, input bad_total,
                    output ready);
endinterface
`default_nettype wire

[rtl/mpfp_front.sv]
// Byte-wide frame parser: finds start bytes, counts header, payload and trailer,
// and captures the position fields. Depends on mpfp_pkg.
`default_nettype none
module mpfp_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            take,
    input  wire logic [7:0]      data,
    output logic                 push,
    output mpfp_pkg::frame_t     frame
);

    mpfp_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [7:0]  plen_reg, plen_next;
    logic        v2_reg, v2_next;
    logic        signed_reg, signed_next;
    logic [23:0] msgid_reg, msgid_next;

    logic [31:0] lat_reg, lon_reg, alt_reg, vel_reg;
    logic [15:0] hdg_reg;

    logic [7:0] cnt_inc;
    logic [7:0] hdr_last;
    logic [7:0] trl_len;

    assign cnt_inc  = cnt_reg + 8'd1;
    assign hdr_last = v2_reg ? mpfp_pkg::HDR_LAST_V2 : mpfp_pkg::HDR_LAST_V1;
    assign trl_len  = (v2_reg && signed_reg) ? mpfp_pkg::TRAILER_SIGNED
                                             : mpfp_pkg::TRAILER_PLAIN;

    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        plen_next   = plen_reg;
        v2_next     = v2_reg;
        signed_next = signed_reg;
        msgid_next  = msgid_reg;
        push        = 1'b0;
        if (take)
        begin
            unique case (phase_reg)
                mpfp_pkg::PH_HUNT:
                begin
                    if (data == mpfp_pkg::STX_V1 || data == mpfp_pkg::STX_V2)
                    begin
                        v2_next     = (data == mpfp_pkg::STX_V2);
                        signed_next = 1'b0;
                        msgid_next  = '0;
                        plen_next   = '0;
                        cnt_next    = 8'd1;
                        phase_next  = mpfp_pkg::PH_HEADER;
                    end
                end
                mpfp_pkg::PH_HEADER:
                begin
                    if (cnt_reg == 8'd1)
                        plen_next = data;
                    else if (v2_reg)
                    begin
                        if (cnt_reg == 8'd2)
                            signed_next = data[mpfp_pkg::INCOMPAT_SIGNED];
                        else if (cnt_reg == 8'd7)
                            msgid_next[7:0] = data;
                        else if (cnt_reg == 8'd8)
                            msgid_next[15:8] = data;
                        else if (cnt_reg == 8'd9)
                            msgid_next[23:16] = data;
                    end
                    else if (cnt_reg == 8'd5)
                        msgid_next = {16'd0, data};
                    cnt_next = cnt_inc;
                    if (cnt_reg == hdr_last)
                    begin
                        cnt_next   = '0;
                        phase_next = (plen_reg == 8'd0) ? mpfp_pkg::PH_TRAILER
                                                        : mpfp_pkg::PH_PAYLOAD;
                    end
                end
                mpfp_pkg::PH_PAYLOAD:
                begin
                    cnt_next = cnt_inc;
                    if (cnt_inc == plen_reg)
                    begin
                        cnt_next   = '0;
                        phase_next = mpfp_pkg::PH_TRAILER;
                    end
                end
                mpfp_pkg::PH_TRAILER:
                begin
                    cnt_next = cnt_inc;
                    if (cnt_inc == trl_len)
                    begin
                        cnt_next   = '0;
                        phase_next = mpfp_pkg::PH_HUNT;
                        push       = (msgid_reg == mpfp_pkg::POS_MSG_ID);
                    end
                end
                default:
                begin
                    cnt_next   = '0;
                    phase_next = mpfp_pkg::PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= mpfp_pkg::PH_HUNT;
            cnt_reg    <= '0;
            plen_reg   <= '0;
            v2_reg     <= 1'b0;
            signed_reg <= 1'b0;
            msgid_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            plen_reg   <= plen_next;
            v2_reg     <= v2_next;
            signed_reg <= signed_next;
            msgid_reg  <= msgid_next;
        end
    end

    // Little-endian field capture; the low offset bits select the byte lane.
    always_ff @(posedge clk)
    begin
        if (take && phase_reg == mpfp_pkg::PH_PAYLOAD)
        begin
            case (cnt_reg)
                8'd4, 8'd5, 8'd6, 8'd7:
                    lat_reg[{cnt_reg[1:0], 3'b000} +: 8] <= data;
                8'd8, 8'd9, 8'd10, 8'd11:
                    lon_reg[{cnt_reg[1:0], 3'b000} +: 8] <= data;
                8'd12, 8'd13, 8'd14, 8'd15:
                    alt_reg[{cnt_reg[1:0], 3'b000} +: 8] <= data;
                8'd20, 8'd21, 8'd22, 8'd23:
                    vel_reg[{cnt_reg[1:0], 3'b000} +: 8] <= data;
                8'd26, 8'd27:
                    hdg_reg[{cnt_reg[0], 3'b000} +: 8] <= data;
                default:
                    ;
            endcase
        end
    end

    assign frame.short_payload = (plen_reg < mpfp_pkg::POS_MIN_LEN);
    assign frame.lat           = lat_reg;
    assign frame.lon           = lon_reg;
    assign frame.alt           = alt_reg;
    assign frame.vel           = vel_reg;
    assign frame.hdg           = hdg_reg;

endmodule
`default_nettype wire

[rtl/mpfp_queue.sv]
// Short first-in first-out queue of finished frames between parser and reporter.
// Depends on mpfp_pkg.
`default_nettype none
module mpfp_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire mpfp_pkg::frame_t wr_frame,
    input  wire logic             pop,
    output mpfp_pkg::frame_t      rd_frame,
    output logic                  not_empty,
    output logic                  full
);

    mpfp_pkg::frame_t slot_reg [mpfp_pkg::QUEUE_DEPTH];
    logic [mpfp_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [mpfp_pkg::QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [mpfp_pkg::QUEUE_CW-1:0] fill_reg, fill_next;

    function automatic logic [mpfp_pkg::QUEUE_AW-1:0] bump(
        input logic [mpfp_pkg::QUEUE_AW-1:0] p);
        if (p == mpfp_pkg::QUEUE_AW'(mpfp_pkg::QUEUE_DEPTH - 1))
            return '0;
        return p + mpfp_pkg::QUEUE_AW'(1);
    endfunction

    assign not_empty = (fill_reg != '0);
    assign full      = (fill_reg == mpfp_pkg::QUEUE_CW'(mpfp_pkg::QUEUE_DEPTH));
    assign rd_frame  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
            fill_next = fill_reg + mpfp_pkg::QUEUE_CW'(1);
        else if (pop && !push)
            fill_next = fill_reg - mpfp_pkg::QUEUE_CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_frame;
    end

endmodule
`default_nettype wire

[rtl/mpfp_back.sv]
// Report stage: judges each queued frame, keeps the good and rejected totals,
// and holds the report word in an output register. Depends on mpfp_pkg.
`default_nettype none
module mpfp_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             avail,
    input  wire mpfp_pkg::frame_t frame,
    output logic                  pop,
    mpfp_pos_if.source            report
);

    logic        valid_reg;
    logic        status_reg;
    logic [31:0] lat_reg, lon_reg, alt_reg;
    logic [15:0] vx_reg, vy_reg, hdg_reg;
    logic        hdg_ok_reg;
    logic [31:0] good_reg, good_next;
    logic [31:0] bad_reg, bad_next;
    logic        reject;

    assign pop    = avail && (!valid_reg || report.ready);
    assign reject = frame.short_payload || (frame.lat == 32'd0 && frame.lon == 32'd0);

    always_comb
    begin
        good_next = good_reg;
        bad_next  = bad_reg;
        if (pop)
        begin
            if (reject)
                bad_next = bad_reg + 32'd1;
            else
                good_next = good_reg + 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            good_reg  <= '0;
            bad_reg   <= '0;
        end
        else
        begin
            if (pop)
                valid_reg <= 1'b1;
            else if (report.ready)
                valid_reg <= 1'b0;
            good_reg <= good_next;
            bad_reg  <= bad_next;
        end
    end

    // A rejected frame reports zeros in every position field.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg <= reject;
            lat_reg    <= reject ? 32'd0 : frame.lat;
            lon_reg    <= reject ? 32'd0 : frame.lon;
            alt_reg    <= reject ? 32'd0 : frame.alt;
            vx_reg     <= reject ? 16'd0 : frame.vel[15:0];
            vy_reg     <= reject ? 16'd0 : frame.vel[31:16];
            hdg_reg    <= reject ? 16'd0 : frame.hdg;
            hdg_ok_reg <= !reject && (frame.hdg != mpfp_pkg::HDG_UNKNOWN);
        end
    end

    assign report.valid         = valid_reg;
    assign report.status        = status_reg;
    assign report.lat_e7        = lat_reg;
    assign report.lon_e7        = lon_reg;
    assign report.alt_mm        = alt_reg;
    assign report.vel_x         = vx_reg;
    assign report.vel_y         = vy_reg;
    assign report.heading_cdeg  = hdg_reg;
    assign report.heading_valid = hdg_ok_reg;
    assign report.good_total    = good_reg;
    assign report.bad_total     = bad_reg;

endmodule
`default_nettype wire

[rtl/mavlink_position_frame_parser_top.sv]
// Position frame parser for a version 1 / version 2 byte stream. It takes one
// byte per clock cycle without pause as long as its two-entry frame queue has
// room. A report is offered once the frame has been written into the queue and
// then loaded into the report register, at the earliest. Only a
// consumer that leaves reports waiting can stall the input, and since every
// frame is at least eight bytes long that takes several reports held back in
// a row. Checksums are not verified.
// Depends on mpfp_pkg, the interfaces, mpfp_front, mpfp_queue and mpfp_back.
`default_nettype none
module mavlink_position_frame_parser_top (
    input  wire logic    clk,
    input  wire logic    rst_n,
    mpfp_byte_if.sink    stream,
    mpfp_pos_if.source   report
);

    logic             take;
    logic             push;
    logic             pop;
    logic             not_empty;
    logic             full;
    mpfp_pkg::frame_t wr_frame;
    mpfp_pkg::frame_t rd_frame;

    assign stream.ready = !full;
    assign take         = stream.valid && !full;

    mpfp_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .data  (stream.byte_in),
        .push  (push),
        .frame (wr_frame)
    );

    mpfp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_frame  (wr_frame),
        .pop       (pop),
        .rd_frame  (rd_frame),
        .not_empty (not_empty),
        .full      (full)
    );

    mpfp_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .avail  (not_empty),
        .frame  (rd_frame),
        .pop    (pop),
        .report (report)
    );

endmodule
`default_nettype wire

[tb/sv/tb_mavlink_position_frame_parser_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for mavlink_position_frame_parser_top: frames go in one byte per word,
// and each position report is checked against a byte-level parser kept alongside the DUT.
// Depends on mpfp_pkg, the channel interfaces in mpfp_ifs and the parser RTL.
module tb_mavlink_position_frame_parser_top;

    localparam int LIMIT_CYCLES   = 200000;
    localparam int SETTLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES   = 50;
    localparam int ITEM_TARGET    = 1750;
    localparam int MIN_RANDOM_POS = 12;
    localparam int HOLD_START     = 1500;
    localparam int HOLD_CYCLES    = 1500;

    // Byte positions inside the header and the position payload.
    localparam int LEN_POS      = 1;
    localparam int FLAGS_POS    = 2;
    localparam int V2_ID_FIRST  = mpfp_pkg::HDR_LAST_V2 - 2;
    localparam int POS_BODY_LEN = 28;
    localparam int LAT_OFS      = 4;
    localparam int LON_OFS      = 8;
    localparam int ALT_OFS      = 12;
    localparam int VEL_OFS      = 20;
    localparam int HDG_OFS      = 26;

    typedef logic [7:0] byte_q_t[$];

    typedef struct packed {
        logic        status;
        logic [31:0] lat;
        logic [31:0] lon;
        logic [31:0] alt;
        logic [15:0] vx;
        logic [15:0] vy;
        logic [15:0] hdg;
        logic        hdg_ok;
        logic [31:0] good;
        logic [31:0] bad;
    } pos_report_t;

    logic clk = 1'b0;
    logic rst_n;

    mpfp_byte_if stream_if ();
    mpfp_pos_if  report_if ();

    mavlink_position_frame_parser_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_if),
        .report (report_if)
    );

    always #5 clk = ~clk;

    byte_q_t     stream_bytes;
    pos_report_t pending_reports[$];
    pos_report_t next_report;
    int          word_total;
    int          words_accepted = 0;
    int          mismatches = 0;
    int          cycle_count = 0;
    int          burst_left;
    int          gap_left;
    int          rx_cycles;
    int          rx_hold;
    int          rx_left;
    logic [15:0] rx_pattern;

    // Parser state mirrored on the testbench side.
    mpfp_pkg::phase_t parse_phase = mpfp_pkg::PH_HUNT;
    logic [8:0]  parse_count = '0;
    logic [7:0]  payload_len = '0;
    logic        frame_v2 = 1'b0;
    logic        frame_signed = 1'b0;
    logic [23:0] frame_msg = '0;
    logic [31:0] cap_lat = '0;
    logic [31:0] cap_lon = '0;
    logic [31:0] cap_alt = '0;
    logic [31:0] cap_vel = '0;
    logic [15:0] cap_hdg = '0;
    logic [31:0] good_seen = '0;
    logic [31:0] bad_seen = '0;

    task automatic parse_stream_byte(input logic [7:0] b);
        pos_report_t rpt;
        logic [7:0]  tail_len;
        case (parse_phase)
            mpfp_pkg::PH_HUNT:
            begin
                if (b == mpfp_pkg::STX_V1 || b == mpfp_pkg::STX_V2)
                begin
                    frame_v2     = (b == mpfp_pkg::STX_V2);
                    frame_signed = 1'b0;
                    frame_msg    = '0;
                    payload_len  = '0;
                    parse_count  = 9'd1;
                    parse_phase  = mpfp_pkg::PH_HEADER;
                end
            end
            mpfp_pkg::PH_HEADER:
            begin
                if (parse_count == LEN_POS)
                    payload_len = b;
                else if (frame_v2)
                begin
                    if (parse_count == FLAGS_POS)
                        frame_signed = b[mpfp_pkg::INCOMPAT_SIGNED];
                    else if (parse_count >= V2_ID_FIRST &&
                             parse_count <= mpfp_pkg::HDR_LAST_V2)
                        frame_msg[(parse_count - V2_ID_FIRST) * 8 +: 8] = b;
                end
                else if (parse_count == mpfp_pkg::HDR_LAST_V1)
                    frame_msg = {16'd0, b};
                parse_count++;
                if (parse_count > (frame_v2 ? mpfp_pkg::HDR_LAST_V2 : mpfp_pkg::HDR_LAST_V1))
                begin
                    parse_count = '0;
                    parse_phase = (payload_len == '0) ? mpfp_pkg::PH_TRAILER
                                                      : mpfp_pkg::PH_PAYLOAD;
                end
            end
            mpfp_pkg::PH_PAYLOAD:
            begin
                if (parse_count >= LAT_OFS && parse_count < LAT_OFS + 4)
                    cap_lat[(parse_count - LAT_OFS) * 8 +: 8] = b;
                else if (parse_count >= LON_OFS && parse_count < LON_OFS + 4)
                    cap_lon[(parse_count - LON_OFS) * 8 +: 8] = b;
                else if (parse_count >= ALT_OFS && parse_count < ALT_OFS + 4)
                    cap_alt[(parse_count - ALT_OFS) * 8 +: 8] = b;
                else if (parse_count >= VEL_OFS && parse_count < VEL_OFS + 4)
                    cap_vel[(parse_count - VEL_OFS) * 8 +: 8] = b;
                else if (parse_count >= HDG_OFS && parse_count < HDG_OFS + 2)
                    cap_hdg[(parse_count - HDG_OFS) * 8 +: 8] = b;
                parse_count++;
                if (parse_count >= payload_len)
                begin
                    parse_count = '0;
                    parse_phase = mpfp_pkg::PH_TRAILER;
                end
            end
            default:
            begin
                parse_count++;
                tail_len = (frame_v2 && frame_signed) ? mpfp_pkg::TRAILER_SIGNED
                                                      : mpfp_pkg::TRAILER_PLAIN;
                if (parse_count >= tail_len)
                begin
                    parse_phase = mpfp_pkg::PH_HUNT;
                    parse_count = '0;
                    if (frame_msg == mpfp_pkg::POS_MSG_ID)
                    begin
                        rpt = '0;
                        if (payload_len < mpfp_pkg::POS_MIN_LEN ||
                            (cap_lat == '0 && cap_lon == '0))
                        begin
                            bad_seen++;
                            rpt.status = 1'b1;
                        end
                        else
                        begin
                            good_seen++;
                            rpt.lat    = cap_lat;
                            rpt.lon    = cap_lon;
                            rpt.alt    = cap_alt;
                            rpt.vx     = cap_vel[15:0];
                            rpt.vy     = cap_vel[31:16];
                            rpt.hdg    = cap_hdg;
                            rpt.hdg_ok = (cap_hdg != mpfp_pkg::HDG_UNKNOWN);
                        end
                        rpt.good = good_seen;
                        rpt.bad  = bad_seen;
                        pending_reports.push_back(rpt);
                    end
                end
            end
        endcase
    endtask

    function automatic byte_q_t noise(input int n);
        byte_q_t q;
        repeat (n) q.push_back(8'($urandom));
        return q;
    endfunction

    // The flags byte carries the signature bit on version 2; on version 1 the same
    // position is the sequence number, so setting the bit there must change nothing.
    function automatic byte_q_t frame_bytes(input bit v2, input bit sig,
                                            input logic [23:0] msg, input byte_q_t body);
        byte_q_t    q;
        logic [7:0] flags;
        flags = 8'($urandom);
        flags[mpfp_pkg::INCOMPAT_SIGNED] = sig;
        q.push_back(v2 ? mpfp_pkg::STX_V2 : mpfp_pkg::STX_V1);
        q.push_back(8'(body.size()));
        q.push_back(flags);
        repeat (v2 ? 4 : 2) q.push_back(8'($urandom));
        q.push_back(msg[7:0]);
        if (v2)
        begin
            q.push_back(msg[15:8]);
            q.push_back(msg[23:16]);
        end
        q = {q, body};
        repeat ((v2 && sig) ? mpfp_pkg::TRAILER_SIGNED : mpfp_pkg::TRAILER_PLAIN)
            q.push_back(8'($urandom));
        return q;
    endfunction

    function automatic byte_q_t pos_body(input int len, input logic [31:0] lat,
                                         input logic [31:0] lon, input logic [31:0] alt,
                                         input logic [15:0] vx, input logic [15:0] vy,
                                         input logic [15:0] hdg);
        byte_q_t    q;
        logic [7:0] img [POS_BODY_LEN];
        foreach (img[i]) img[i] = 8'($urandom);
        for (int k = 0; k < 4; k++)
        begin
            img[LAT_OFS + k] = lat[8 * k +: 8];
            img[LON_OFS + k] = lon[8 * k +: 8];
            img[ALT_OFS + k] = alt[8 * k +: 8];
        end
        for (int k = 0; k < 2; k++)
        begin
            img[VEL_OFS + k]     = vx[8 * k +: 8];
            img[VEL_OFS + 2 + k] = vy[8 * k +: 8];
            img[HDG_OFS + k]     = hdg[8 * k +: 8];
        end
        for (int i = 0; i < len; i++)
            q.push_back((i < POS_BODY_LEN) ? img[i] : 8'($urandom));
        return q;
    endfunction

    task automatic add_pos(input bit v2, input bit sig, input int len,
                           input logic [31:0] lat, input logic [31:0] lon,
                           input logic [31:0] alt, input logic [15:0] vx,
                           input logic [15:0] vy, input logic [15:0] hdg);
        stream_bytes = {stream_bytes,
                        frame_bytes(v2, sig, mpfp_pkg::POS_MSG_ID,
                                    pos_body(len, lat, lon, alt, vx, vy, hdg))};
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Sender: bursts of words with random gaps; a word on offer is held until taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream_if.valid   <= 1'b0;
            stream_if.byte_in <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (stream_if.valid && stream_if.ready)
            begin
                parse_stream_byte(stream_if.byte_in);
                void'(stream_bytes.pop_front());
                words_accepted++;
            end
            if (!(stream_if.valid && !stream_if.ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    stream_if.valid <= 1'b0;
                end
                else if (stream_bytes.size() == 0)
                    stream_if.valid <= 1'b0;
                else
                begin
                    stream_if.valid   <= 1'b1;
                    stream_if.byte_in <= stream_bytes[0];
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // Receiver: a rotating ready pattern reloaded now and then, plus one long hold-off
    // that lets reports pile up until the parser has to stop taking words.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            report_if.ready <= 1'b0;
            rx_cycles  = 0;
            rx_hold    = 0;
            rx_left    = 0;
            rx_pattern = '1;
        end
        else
        begin
            rx_cycles++;
            if (rx_cycles == HOLD_START)
                rx_hold = HOLD_CYCLES;
            if (rx_hold > 0)
            begin
                rx_hold--;
                report_if.ready <= 1'b0;
            end
            else
            begin
                if (rx_left == 0)
                begin
                    rx_left = $urandom_range(20, 200);
                    case ($urandom_range(0, 2))
                        0: rx_pattern = '1;
                        1: rx_pattern = 16'($urandom);
                        default: rx_pattern = 16'($urandom & $urandom);
                    endcase
                end
                rx_left--;
                report_if.ready <= rx_pattern[0];
                rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && report_if.valid && report_if.ready)
        begin
            if (pending_reports.size() == 0)
            begin
                $display("%0t: report with none expected, expected nothing, got lat %h lon %h",
                         $time, report_if.lat_e7, report_if.lon_e7);
                mismatches++;
            end
            else
            begin
                next_report = pending_reports.pop_front();
                check_field("status", 32'(next_report.status), 32'(report_if.status));
                check_field("lat_e7", next_report.lat, report_if.lat_e7);
                check_field("lon_e7", next_report.lon, report_if.lon_e7);
                check_field("alt_mm", next_report.alt, report_if.alt_mm);
                check_field("vel_x", {16'd0, next_report.vx}, {16'd0, report_if.vel_x});
                check_field("vel_y", {16'd0, next_report.vy}, {16'd0, report_if.vel_y});
                check_field("heading_cdeg", 32'(next_report.hdg),
                            32'(report_if.heading_cdeg));
                check_field("heading_valid", 32'(next_report.hdg_ok),
                            32'(report_if.heading_valid));
                check_field("good_total", next_report.good, report_if.good_total);
                check_field("bad_total", next_report.bad, report_if.bad_total);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("mavlink_position_frame_parser_top test failed");
            $finish;
        end
    end

    initial
    begin
        byte_q_t     body;
        int          r;
        int          len;
        int          random_pos;
        int          settle;
        bit          v2;
        bit          sig;
        logic [31:0] lat;
        logic [31:0] lon;
        logic [23:0] id;

        rst_n = 1'b0;

        // Directed frames: field extremes, both versions, and the corner cases.
        stream_bytes = {8'h00, 8'hFF, 8'h55, 8'hAA, 8'h7E, 8'hFC};
        add_pos(0, 1, 28, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 16'h7FFF, 16'h8000, 16'h0);
        add_pos(1, 0, 28, 32'hFFFF_FFFF, 32'h1, 32'h7FFF_FFFF, 16'h8000, 16'h7FFF,
                mpfp_pkg::HDG_UNKNOWN);
        add_pos(1, 1, 40, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 16'h1,
                mpfp_pkg::HDG_UNKNOWN - 16'd1);
        // Short payload and zero position are both rejected.
        add_pos(0, 0, 27, 32'h1, 32'h1, 32'h1, 16'h1, 16'h1, 16'h1);
        add_pos(1, 0, 28, 32'h0, 32'h0, 32'h5, 16'h5, 16'h5, 16'h5);
        add_pos(0, 0, 0, 32'h1, 32'h1, 32'h1, 16'h1, 16'h1, 16'h1);
        add_pos(1, 1, 0, 32'h1, 32'h1, 32'h1, 16'h1, 16'h1, 16'h1);
        // Low id byte matches but the top id byte does not: no report.
        stream_bytes = {stream_bytes, frame_bytes(1, 0, 24'h01_0021,
                        pos_body(28, 32'h1, 32'h2, 32'h3, 16'h4, 16'h5, 16'h6))};
        // Start bytes inside the payload must not restart the frame.
        add_pos(1, 0, 28, 32'hFEFD_FEFD, 32'hFDFE_FDFE, 32'hFDFD_FDFD, 16'hFEFE, 16'hFDFD,
                16'hFEFD);
        add_pos(0, 0, 255, 32'h0, 32'h1, 32'hFFFF_FFFF, 16'h0, 16'h0, 16'd12345);
        stream_bytes = {stream_bytes, frame_bytes(1, 1, 24'hFF_FFFF, noise(0))};
        stream_bytes = {stream_bytes, frame_bytes(0, 0, 24'd255, noise(255))};
        stream_bytes = {stream_bytes, frame_bytes(0, 0, 24'd0, noise(3))};

        // Random part: mostly whole frames, with noise and cut-off frames mixed in.
        random_pos = 0;
        while (stream_bytes.size() < ITEM_TARGET || random_pos < MIN_RANDOM_POS)
        begin
            r   = $urandom_range(0, 99);
            v2  = $urandom_range(0, 1);
            sig = v2 && ($urandom_range(0, 3) == 0);
            if (r < 55)
            begin
                case ($urandom_range(0, 24))
                    0, 1: len = $urandom_range(0, 27);
                    2, 3, 4: len = $urandom_range(29, 60);
                    default: len = 28;
                endcase
                lat = pick_word();
                lon = pick_word();
                if ($urandom_range(0, 11) == 0)
                begin
                    lat = '0;
                    lon = '0;
                end
                add_pos(v2, sig, len, lat, lon, pick_word(), 16'(pick_word() >> 16),
                        16'(pick_word() >> 16),
                        ($urandom_range(0, 5) == 0) ? mpfp_pkg::HDG_UNKNOWN
                                                    : 16'(pick_word() >> 16));
                random_pos++;
            end
            else if (r < 80)
            begin
                id = v2 ? 24'($urandom) : 24'($urandom_range(0, 255));
                if (id == mpfp_pkg::POS_MSG_ID)
                    id = 24'd0;
                stream_bytes = {stream_bytes, frame_bytes(v2, sig, id,
                                noise($urandom_range(0, 40)))};
            end
            else if (r < 92)
                stream_bytes = {stream_bytes, noise($urandom_range(1, 6))};
            else
            begin
                body = frame_bytes(v2, sig, mpfp_pkg::POS_MSG_ID,
                                   pos_body(28, pick_word(), pick_word(), pick_word(),
                                            16'($urandom), 16'($urandom), 16'($urandom)));
                stream_bytes = {stream_bytes, body[0:$urandom_range(1, body.size() - 2)]};
            end
        end
        word_total = stream_bytes.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        wait (words_accepted == word_total);
        settle = 0;
        while (pending_reports.size() != 0 && settle < SETTLE_LIMIT)
        begin
            @(posedge clk);
            settle++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_reports.size() != 0)
        begin
            $display("%0t: expected %0d more reports, got none", $time, pending_reports.size());
            mismatches++;
        end

        if (mismatches == 0)
            $display("mavlink_position_frame_parser_top test passed");
        else
            $display("mavlink_position_frame_parser_top test failed");
        $finish;
    end

endmodule

[mavlink_position_frame_parser_top.f]
rtl/mpfp_pkg.sv
rtl/mpfp_ifs.sv
rtl/mpfp_front.sv
rtl/mpfp_queue.sv
rtl/mpfp_back.sv
rtl/mavlink_position_frame_parser_top.sv
tb/sv/tb_mavlink_position_frame_parser_top.sv
